@@ design/smaf_pkg.sv @@
// Package for the shape-masked alpha fill block: widths, register codes,
// shared configuration type and the divide-by-255 helper. No dependencies.
`timescale 1ns / 1ps

package smaf_pkg;

	localparam int PIX_W   = 11;  // pixel coordinate
	localparam int COORD_W = 12;  // signed geometry register
	localparam int DIFF_W  = 13;  // signed pixel minus center
	localparam int SQ_W    = 24;  // dx*dx or dy*dy
	localparam int RSQ_W   = 22;  // radius squared, radius < 2048
	localparam int SUM_W   = 25;  // dx*dx + dy*dy
	localparam int COLOR_W = 32;
	localparam int CHAN_W  = 8;
	localparam int PROD_W  = 16;  // channel times weight
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;
	localparam logic [CHAN_W-1:0]  ALPHA_FORCED = 8'hFF;
	localparam logic [COLOR_W-1:0] FILL_RESET   = 32'hFF00_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHAPE_MODE  = 3'd0,
		CFG_LEFT_CX     = 3'd1,
		CFG_TOP_CY      = 3'd2,
		CFG_RIGHT_R     = 3'd3,
		CFG_BOTTOM      = 3'd4,
		CFG_FILL_COLOR  = 3'd5,
		CFG_ALPHA_LEVEL = 3'd6
	} cfg_idx_t;

	localparam logic SHAPE_RECT   = 1'b0;
	localparam logic SHAPE_CIRCLE = 1'b1;

	typedef struct packed {
		logic                             shape_mode;
		logic signed [COORD_W-1:0]        left_or_center_x;
		logic signed [COORD_W-1:0]        top_or_center_y;
		logic signed [COORD_W-1:0]        right_or_radius;
		logic signed [COORD_W-1:0]        bottom_edge;
		logic        [COLOR_W-1:0]        fill_color;
		logic        [CHAN_W-1:0]         alpha_level;
	} smaf_cfg_t;

	// Load enables of the three working stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} smaf_adv_t;

	// Exact floor(n/255) for n <= 255*255.
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] n);
		logic [PROD_W:0] t;
		t = {1'b0, n} + {9'd0, n[PROD_W-1:CHAN_W]} + 17'd1;
		return t[PROD_W-1:CHAN_W];
	endfunction

endpackage

@@ design/smaf_if.sv @@
// Valid/ready channel interfaces for pixels in and results out.
// Depends on smaf_pkg.
`timescale 1ns / 1ps

interface smaf_pix_if;
	import smaf_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;
	logic [COLOR_W-1:0] dest_color;
	modport source(output valid, pixel_x, pixel_y, dest_color, input ready);
	modport sink(input valid, pixel_x, pixel_y, dest_color, output ready);
endinterface

interface smaf_res_if;
	import smaf_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] new_color;
	logic               covered;
	modport source(output valid, new_color, covered, input ready);
	modport sink(input valid, new_color, covered, output ready);
endinterface

@@ design/smaf_cover.sv @@
// Coverage pipeline: rectangle compares and circle distance test over
// three register stages. Depends on smaf_pkg.
`timescale 1ns / 1ps

module smaf_cover (
	input  logic                       clk,
	input  smaf_pkg::smaf_adv_t        adv,
	input  smaf_pkg::smaf_cfg_t        cfg,
	input  logic [smaf_pkg::PIX_W-1:0] pixel_x,
	input  logic [smaf_pkg::PIX_W-1:0] pixel_y,
	output logic                       covered_s3
);
	import smaf_pkg::*;

	logic signed [DIFF_W-1:0]   xs, ys, cx, cy, lft, rgt, top, bot;
	logic signed [DIFF_W-1:0]   dx_s1, dy_s1;
	logic                       rect_s1, rect_s2;
	logic [RSQ_W-1:0]           rr_s1, rr_s2;
	logic signed [2*DIFF_W-1:0] dxx, dyy;
	logic [SQ_W-1:0]            dxx_s2, dyy_s2;
	logic [SUM_W-1:0]           dist_sq;

	assign xs  = signed'({2'b00, pixel_x});
	assign ys  = signed'({2'b00, pixel_y});
	assign cx  = DIFF_W'(cfg.left_or_center_x);
	assign cy  = DIFF_W'(cfg.top_or_center_y);
	assign lft = cx;
	assign top = cy;
	assign rgt = DIFF_W'(cfg.right_or_radius);
	assign bot = DIFF_W'(cfg.bottom_edge);

	// stage 1: differences, rectangle test, radius squared
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			dx_s1   <= xs - cx;
			dy_s1   <= ys - cy;
			rect_s1 <= (xs >= lft) && (xs < rgt) && (ys >= top) && (ys < bot);
			rr_s1   <= RSQ_W'(cfg.right_or_radius[COORD_W-2:0])
				* RSQ_W'(cfg.right_or_radius[COORD_W-2:0]);
		end
	end

	// stage 2: squares
	assign dxx = (2*DIFF_W)'(dx_s1) * (2*DIFF_W)'(dx_s1);
	assign dyy = (2*DIFF_W)'(dy_s1) * (2*DIFF_W)'(dy_s1);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			dxx_s2  <= dxx[SQ_W-1:0];
			dyy_s2  <= dyy[SQ_W-1:0];
			rect_s2 <= rect_s1;
			rr_s2   <= rr_s1;
		end
	end

	// stage 3: sum and compare; negative radius covers nothing
	assign dist_sq = {1'b0, dxx_s2} + {1'b0, dyy_s2};

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			if (cfg.shape_mode == SHAPE_CIRCLE)
				covered_s3 <= !cfg.right_or_radius[COORD_W-1]
					&& (dist_sq <= SUM_W'(rr_s2));
			else
				covered_s3 <= rect_s2;
		end
	end

endmodule

@@ design/smaf_blend.sv @@
// Blend pipeline: per-channel weighted products, sum, divide by 255 and
// opaque select, over three register stages. Depends on smaf_pkg.
`timescale 1ns / 1ps

module smaf_blend (
	input  logic                         clk,
	input  smaf_pkg::smaf_adv_t          adv,
	input  smaf_pkg::smaf_cfg_t          cfg,
	input  logic [smaf_pkg::COLOR_W-1:0] dest_color,
	output logic [smaf_pkg::COLOR_W-1:0] mixed_s3,
	output logic [smaf_pkg::COLOR_W-1:0] dest_s3
);
	import smaf_pkg::*;

	localparam int NCH = 3;

	logic [PROD_W-1:0]  ps_s1 [NCH];
	logic [PROD_W-1:0]  pd_s1 [NCH];
	logic [PROD_W-1:0]  n_s2  [NCH];
	logic [COLOR_W-1:0] dest_s1, dest_s2;
	logic               opaque_s1, opaque_s2;
	logic [CHAN_W-1:0]  inv_a;
	logic [CHAN_W-1:0]  q [NCH];

	assign inv_a = ALPHA_OPAQUE - cfg.alpha_level;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			for (int c = 0; c < NCH; c++) begin
				ps_s1[c] <= PROD_W'(cfg.fill_color[c*CHAN_W +: CHAN_W])
					* PROD_W'(cfg.alpha_level);
				pd_s1[c] <= PROD_W'(dest_color[c*CHAN_W +: CHAN_W]) * PROD_W'(inv_a);
			end
			dest_s1   <= dest_color;
			opaque_s1 <= (cfg.alpha_level == ALPHA_OPAQUE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int c = 0; c < NCH; c++)
				n_s2[c] <= ps_s1[c] + pd_s1[c];
			dest_s2   <= dest_s1;
			opaque_s2 <= opaque_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++)
			q[c] = div255(n_s2[c]);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			if (opaque_s2)
				mixed_s3 <= cfg.fill_color;
			else
				mixed_s3 <= {ALPHA_FORCED, q[2], q[1], q[0]};
			dest_s3 <= dest_s2;
		end
	end

endmodule

@@ design/shape_masked_alpha_fill.sv @@
// Top level of the shape-masked alpha fill block: configuration registers,
// pipeline handshake control and output register.
// Depends on smaf_pkg, smaf_if, smaf_cover and smaf_blend.
`timescale 1ns / 1ps

// Usage
//   pixel  : sink channel, one transaction per destination pixel (x, y, ARGB).
//   result : source channel, one transaction per pixel, same order:
//            new_color and covered.
//   cfg_*  : write port; cfg_we with cfg_index selects one of seven registers
//            (shape mode, four geometry values, fill color, alpha). Indexes
//            past the list are ignored. Write only while the pipe is empty.
// Path: the accepting edge loads stage 1; the pixel then moves through
//   stages 2 and 3 to the output register, which presents it on result.
// Throughput: one pixel per clock while result is not stalled, set by the fully pipelined datapath:
//   the squares and the channel products each sit in their own stage.
// Stall: each stage holds while its successor is full and stalled; a bubble
//   anywhere lets the stages behind it move up, so pixel.ready stays high
//   while the result register waits, until all four stages are full.
// Reset: arst_n clears all valid bits and loads the register defaults
//   (rectangle at the origin, fill 0xFF000000, alpha 255).

module shape_masked_alpha_fill (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smaf_pkg::CFG_DATA_W-1:0] cfg_data,
	smaf_pix_if.sink                        pixel,
	smaf_res_if.source                      result
);
	import smaf_pkg::*;

	smaf_cfg_t          cfg_q;
	smaf_adv_t          adv;
	logic               v_s1, v_s2, v_s3;
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_cov_q;
	logic               adv_out;
	logic               covered_s3;
	logic [COLOR_W-1:0] mixed_s3, dest_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_mode       <= SHAPE_RECT;
			cfg_q.left_or_center_x <= '0;
			cfg_q.top_or_center_y  <= '0;
			cfg_q.right_or_radius  <= '0;
			cfg_q.bottom_edge      <= '0;
			cfg_q.fill_color       <= FILL_RESET;
			cfg_q.alpha_level      <= ALPHA_OPAQUE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SHAPE_MODE:  cfg_q.shape_mode       <= cfg_data[0];
				CFG_LEFT_CX:     cfg_q.left_or_center_x <= signed'(cfg_data[COORD_W-1:0]);
				CFG_TOP_CY:      cfg_q.top_or_center_y  <= signed'(cfg_data[COORD_W-1:0]);
				CFG_RIGHT_R:     cfg_q.right_or_radius  <= signed'(cfg_data[COORD_W-1:0]);
				CFG_BOTTOM:      cfg_q.bottom_edge      <= signed'(cfg_data[COORD_W-1:0]);
				CFG_FILL_COLOR:  cfg_q.fill_color       <= cfg_data[COLOR_W-1:0];
				CFG_ALPHA_LEVEL: cfg_q.alpha_level      <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its contents move on this cycle.
	assign adv_out = !out_valid_q || result.ready;
	assign adv.s3  = !v_s3 || adv_out;
	assign adv.s2  = !v_s2 || adv.s3;
	assign adv.s1  = !v_s1 || adv.s2;

	assign pixel.ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv.s1)
				v_s1 <= pixel.valid;
			if (adv.s2)
				v_s2 <= v_s1;
			if (adv.s3)
				v_s3 <= v_s2;
			if (adv_out)
				out_valid_q <= v_s3;
		end
	end

	smaf_cover u_cover (
		.clk        (clk),
		.adv        (adv),
		.cfg        (cfg_q),
		.pixel_x    (pixel.pixel_x),
		.pixel_y    (pixel.pixel_y),
		.covered_s3 (covered_s3)
	);

	smaf_blend u_blend (
		.clk        (clk),
		.adv        (adv),
		.cfg        (cfg_q),
		.dest_color (pixel.dest_color),
		.mixed_s3   (mixed_s3),
		.dest_s3    (dest_s3)
	);

	// Output register: uncovered pixels pass through untouched.
	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_color_q <= covered_s3 ? mixed_s3 : dest_s3;
			out_cov_q   <= covered_s3;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.new_color = out_color_q;
	assign result.covered   = out_cov_q;

endmodule
